// File: design/dnms_pkg.sv
// Shared types, constants and helpers for the detection decode and suppression core.
// Used by the decode pipeline, the suppression engine, the top level and the checker.
// No dependencies.
package dnms_pkg;

    localparam int MAX_KEPT_DEF = 64;
    localparam int MIN_AREA     = 100;
    localparam int SCORE_ONE    = 32768;
    localparam int DIM_MAX      = 4096;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    localparam logic [15:0] SCORE_THR_RST   = 16'd9830;
    localparam logic [15:0] OVERLAP_THR_RST = 16'd9830;
    localparam logic [12:0] IMG_DIM_RST     = 13'd640;
    localparam logic [19:0] SCALE_RST       = 20'd65536;

    typedef enum logic [2:0] {
        REG_SCORE_THR   = 3'd0,
        REG_OVERLAP_THR = 3'd1,
        REG_IMG_W       = 3'd2,
        REG_IMG_H       = 3'd3,
        REG_SCALE_X     = 3'd4,
        REG_SCALE_Y     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] box_w;
        logic [15:0] box_h;
        logic [15:0] objectness;
        logic [15:0] class_score_a;
        logic [15:0] class_score_b;
        logic [15:0] class_score_c;
        logic        frame_end;
    } row_t;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [11:0] span_x;
        logic [11:0] span_y;
        logic [15:0] score;
        logic [1:0]  label;
        logic        final_res;
        logic        no_boxes;
        logic        dropped;
    } det_t;

    // one stored box with its confidence
    typedef struct packed {
        logic [11:0] left;
        logic [11:0] top;
        logic [11:0] span_x;
        logic [11:0] span_y;
        logic [15:0] conf;
        logic [1:0]  label;
    } rec_t;

    typedef struct packed {
        logic valid;
        logic keep;
        logic frame_end;
        rec_t rec;
    } dec_out_t;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_START,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_PICK,
        ST_CHK_RD,
        ST_CHK_DATA,
        ST_CHK_MUL,
        ST_CHK_UNI,
        ST_CHK_CMP,
        ST_ACCEPT,
        ST_NEXT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_MARK,
        ST_EMIT_WAIT
    } eng_state_t;

    function automatic logic [15:0] sat_score(input logic [15:0] v);
        sat_score = (v > 16'(SCORE_ONE)) ? 16'(SCORE_ONE) : v;
    endfunction

    function automatic logic [12:0] sat_dim(input logic [12:0] v);
        sat_dim = (v > 13'(DIM_MAX)) ? 13'(DIM_MAX) : v;
    endfunction

endpackage

// File: design/dnms_decode.sv
// Four-stage row decode: class pick, confidence, box scaling, clipping and size filter.
// Depends on dnms_pkg.
module dnms_decode
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  dnms_pkg::row_t     row,
    input  logic [15:0]        score_threshold,
    input  logic [12:0]        image_width,
    input  logic [12:0]        image_height,
    input  logic [19:0]        scale_x,
    input  logic [19:0]        scale_y,
    output dnms_pkg::dec_out_t dec
);

    // stage 1
    logic               v1_reg, fe1_reg;
    logic [15:0]        obj1_reg, best1_reg;
    logic [1:0]         lab1_reg;
    logic signed [17:0] ax1_reg, ay1_reg;
    logic [17:0]        bx1_reg, by1_reg;
    // stage 2
    logic               v2_reg, fe2_reg;
    logic [15:0]        conf2_reg;
    logic [1:0]         lab2_reg;
    logic [13:0]        px2_reg, py2_reg;
    logic [14:0]        qx2_reg, qy2_reg;
    // stage 3
    logic               v3_reg, fe3_reg, keep3_reg;
    dnms_pkg::rec_t     rec3_reg;
    // stage 4
    logic               v4_reg, keep4_reg, fe4_reg;
    dnms_pkg::rec_t     rec4_reg;

    logic [15:0]        sa, sb, sc, best_next, obj_next;
    logic [1:0]         lab_next;
    logic [31:0]        conf_prod;
    logic [36:0]        px_prod, py_prod;
    logic [37:0]        qx_prod, qy_prod;
    logic signed [15:0] lim_x, lim_y, qcx, qcy, len_x, len_y;
    logic [23:0]        area;

    always_comb
    begin
        sa = dnms_pkg::sat_score(row.class_score_a);
        sb = dnms_pkg::sat_score(row.class_score_b);
        sc = dnms_pkg::sat_score(row.class_score_c);
        obj_next = dnms_pkg::sat_score(row.objectness);
        best_next = sa;
        lab_next = 2'd0;
        if (sb > best_next)
        begin
            best_next = sb;
            lab_next = 2'd1;
        end
        if (sc > best_next)
        begin
            best_next = sc;
            lab_next = 2'd2;
        end
    end

    always_comb
    begin
        conf_prod = obj1_reg * best1_reg;
        px_prod = ax1_reg[16:0] * scale_x;
        py_prod = ay1_reg[16:0] * scale_y;
        qx_prod = bx1_reg * scale_x;
        qy_prod = by1_reg * scale_y;
    end

    always_comb
    begin
        lim_x = $signed({3'b000, dnms_pkg::sat_dim(image_width)}) - 16'sd1;
        lim_y = $signed({3'b000, dnms_pkg::sat_dim(image_height)}) - 16'sd1;
        qcx = ($signed({1'b0, qx2_reg}) > lim_x) ? lim_x : $signed({1'b0, qx2_reg});
        qcy = ($signed({1'b0, qy2_reg}) > lim_y) ? lim_y : $signed({1'b0, qy2_reg});
        len_x = qcx - $signed({2'b00, px2_reg});
        len_y = qcy - $signed({2'b00, py2_reg});
        area = rec3_reg.span_x * rec3_reg.span_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fe1_reg <= row.frame_end;
        obj1_reg <= obj_next;
        best1_reg <= best_next;
        lab1_reg <= lab_next;
        ax1_reg <= $signed({1'b0, row.center_x, 1'b0}) - $signed({2'b00, row.box_w});
        ay1_reg <= $signed({1'b0, row.center_y, 1'b0}) - $signed({2'b00, row.box_h});
        bx1_reg <= {1'b0, row.center_x, 1'b0} + {2'b00, row.box_w};
        by1_reg <= {1'b0, row.center_y, 1'b0} + {2'b00, row.box_h};

        fe2_reg <= fe1_reg;
        lab2_reg <= lab1_reg;
        conf2_reg <= conf_prod[30:15];
        px2_reg <= ax1_reg[17] ? 14'd0 : px_prod[36:23];
        py2_reg <= ay1_reg[17] ? 14'd0 : py_prod[36:23];
        qx2_reg <= qx_prod[37:23];
        qy2_reg <= qy_prod[37:23];

        fe3_reg <= fe2_reg;
        keep3_reg <= (conf2_reg >= score_threshold) && (len_x > 16'sd0) && (len_y > 16'sd0);
        rec3_reg.left <= px2_reg[11:0];
        rec3_reg.top <= py2_reg[11:0];
        rec3_reg.span_x <= len_x[11:0];
        rec3_reg.span_y <= len_y[11:0];
        rec3_reg.conf <= conf2_reg;
        rec3_reg.label <= lab2_reg;

        fe4_reg <= fe3_reg;
        keep4_reg <= keep3_reg && (area >= 24'(dnms_pkg::MIN_AREA));
        rec4_reg <= rec3_reg;
    end

    assign dec = '{valid: v4_reg, keep: keep4_reg, frame_end: fe4_reg, rec: rec4_reg};

endmodule

// File: design/dnms_engine.sv
// Box store and suppression engine: stores kept rows, picks boxes in confidence order,
// tests each against the survivors and emits them. Depends on dnms_pkg.
module dnms_engine
#(
    parameter int MAX_KEPT = dnms_pkg::MAX_KEPT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dnms_pkg::dec_out_t dec,
    input  logic [15:0]        overlap_threshold,
    output logic               out_valid,
    input  logic               out_stall,
    output dnms_pkg::det_t     out_data,
    output logic               done
);

    localparam int IDX_W = $clog2(MAX_KEPT);
    localparam int CNT_W = $clog2(MAX_KEPT + 1);

    dnms_pkg::eng_state_t state_reg, state_next;

    dnms_pkg::rec_t row_mem [MAX_KEPT];
    dnms_pkg::rec_t surv_mem [MAX_KEPT];
    dnms_pkg::rec_t row_rd_reg, surv_rd_reg, cand_reg;
    dnms_pkg::det_t out_reg;

    logic [CNT_W-1:0]    cnt_reg, rank_reg, surv_cnt_reg;
    logic                ovf_reg, found_reg;
    logic [MAX_KEPT-1:0] taken_reg;
    logic [IDX_W-1:0]    scan_reg, best_reg, chk_reg, emit_reg, surv_addr;
    logic [11:0]         iw_reg, ih_reg, ssx_reg, ssy_reg;
    logic [23:0]         inter_reg, area_s_reg, area_c_reg;
    logic [24:0]         union_reg;

    logic row_wr, surv_wr, scan_last, chk_last, rank_last, better, overlap;
    logic [12:0] x2, y2;
    logic [11:0] x1, y1;
    logic signed [13:0] dx, dy;
    logic [40:0] lhs, rhs;

    assign scan_last = (CNT_W'(scan_reg) + 1'b1) == cnt_reg;
    assign chk_last  = (CNT_W'(chk_reg) + 1'b1) == surv_cnt_reg;
    assign rank_last = (rank_reg + 1'b1) == cnt_reg;
    assign better    = !taken_reg[scan_reg] && (!found_reg || row_rd_reg.conf > cand_reg.conf);

    // intersection extents between the candidate and one survivor
    always_comb
    begin
        x1 = (cand_reg.left > surv_rd_reg.left) ? cand_reg.left : surv_rd_reg.left;
        y1 = (cand_reg.top > surv_rd_reg.top) ? cand_reg.top : surv_rd_reg.top;
        x2 = ((13'(cand_reg.left) + 13'(cand_reg.span_x))
              < (13'(surv_rd_reg.left) + 13'(surv_rd_reg.span_x)))
             ? 13'(cand_reg.left) + 13'(cand_reg.span_x)
             : 13'(surv_rd_reg.left) + 13'(surv_rd_reg.span_x);
        y2 = ((13'(cand_reg.top) + 13'(cand_reg.span_y))
              < (13'(surv_rd_reg.top) + 13'(surv_rd_reg.span_y)))
             ? 13'(cand_reg.top) + 13'(cand_reg.span_y)
             : 13'(surv_rd_reg.top) + 13'(surv_rd_reg.span_y);
        dx = $signed({1'b0, x2}) - $signed({2'b00, x1});
        dy = $signed({1'b0, y2}) - $signed({2'b00, y1});
        lhs = {2'b00, inter_reg, 15'd0};
        rhs = overlap_threshold * union_reg;
        overlap = lhs > rhs;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dnms_pkg::ST_COLLECT:
                if (dec.valid && dec.frame_end)
                    state_next = dnms_pkg::ST_START;
            dnms_pkg::ST_START:
                state_next = (cnt_reg == '0) ? dnms_pkg::ST_MARK : dnms_pkg::ST_SCAN_RD;
            dnms_pkg::ST_SCAN_RD:
                state_next = dnms_pkg::ST_SCAN_CMP;
            dnms_pkg::ST_SCAN_CMP:
                state_next = scan_last ? dnms_pkg::ST_PICK : dnms_pkg::ST_SCAN_RD;
            dnms_pkg::ST_PICK:
                state_next = (surv_cnt_reg == '0) ? dnms_pkg::ST_ACCEPT : dnms_pkg::ST_CHK_RD;
            dnms_pkg::ST_CHK_RD:
                state_next = dnms_pkg::ST_CHK_DATA;
            dnms_pkg::ST_CHK_DATA:
                state_next = dnms_pkg::ST_CHK_MUL;
            dnms_pkg::ST_CHK_MUL:
                state_next = dnms_pkg::ST_CHK_UNI;
            dnms_pkg::ST_CHK_UNI:
                state_next = dnms_pkg::ST_CHK_CMP;
            dnms_pkg::ST_CHK_CMP:
                priority if (overlap)
                    state_next = dnms_pkg::ST_NEXT;
                else if (chk_last)
                    state_next = dnms_pkg::ST_ACCEPT;
                else
                    state_next = dnms_pkg::ST_CHK_RD;
            dnms_pkg::ST_ACCEPT:
                state_next = dnms_pkg::ST_NEXT;
            dnms_pkg::ST_NEXT:
                state_next = rank_last ? dnms_pkg::ST_EMIT_RD : dnms_pkg::ST_SCAN_RD;
            dnms_pkg::ST_EMIT_RD:
                state_next = dnms_pkg::ST_EMIT_LD;
            dnms_pkg::ST_EMIT_LD:
                state_next = dnms_pkg::ST_EMIT_WAIT;
            dnms_pkg::ST_MARK:
                state_next = dnms_pkg::ST_EMIT_WAIT;
            dnms_pkg::ST_EMIT_WAIT:
                if (!out_stall)
                    state_next = out_reg.final_res ? dnms_pkg::ST_COLLECT : dnms_pkg::ST_EMIT_RD;
            default:
                state_next = dnms_pkg::ST_COLLECT;
        endcase
    end

    always_comb
    begin
        row_wr = 1'b0;
        surv_wr = 1'b0;
        out_valid = 1'b0;
        done = 1'b0;
        surv_addr = chk_reg;
        unique case (state_reg)
            dnms_pkg::ST_COLLECT:
                row_wr = dec.valid && dec.keep && (cnt_reg != CNT_W'(MAX_KEPT));
            dnms_pkg::ST_ACCEPT:
                surv_wr = 1'b1;
            dnms_pkg::ST_EMIT_RD, dnms_pkg::ST_EMIT_LD:
                surv_addr = emit_reg;
            dnms_pkg::ST_EMIT_WAIT:
            begin
                surv_addr = emit_reg;
                out_valid = 1'b1;
                done = !out_stall && out_reg.final_res;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (row_wr)
            row_mem[cnt_reg[IDX_W-1:0]] <= dec.rec;
        row_rd_reg <= row_mem[scan_reg];
    end

    always_ff @(posedge clk)
    begin
        if (surv_wr)
            surv_mem[surv_cnt_reg[IDX_W-1:0]] <= cand_reg;
        surv_rd_reg <= surv_mem[surv_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dnms_pkg::ST_COLLECT;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            taken_reg <= '0;
            rank_reg <= '0;
            surv_cnt_reg <= '0;
            scan_reg <= '0;
            found_reg <= 1'b0;
            chk_reg <= '0;
            emit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                dnms_pkg::ST_COLLECT:
                    if (dec.valid && dec.keep)
                    begin
                        if (row_wr)
                            cnt_reg <= cnt_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                    end
                dnms_pkg::ST_START:
                begin
                    taken_reg <= '0;
                    rank_reg <= '0;
                    surv_cnt_reg <= '0;
                    scan_reg <= '0;
                    found_reg <= 1'b0;
                    emit_reg <= '0;
                end
                dnms_pkg::ST_SCAN_CMP:
                begin
                    if (better)
                    begin
                        best_reg <= scan_reg;
                        found_reg <= 1'b1;
                    end
                    if (!scan_last)
                        scan_reg <= scan_reg + 1'b1;
                end
                dnms_pkg::ST_PICK:
                begin
                    taken_reg[best_reg] <= 1'b1;
                    chk_reg <= '0;
                end
                dnms_pkg::ST_CHK_CMP:
                    if (!overlap && !chk_last)
                        chk_reg <= chk_reg + 1'b1;
                dnms_pkg::ST_ACCEPT:
                    surv_cnt_reg <= surv_cnt_reg + 1'b1;
                dnms_pkg::ST_NEXT:
                begin
                    rank_reg <= rank_reg + 1'b1;
                    scan_reg <= '0;
                    found_reg <= 1'b0;
                end
                dnms_pkg::ST_EMIT_WAIT:
                    if (!out_stall)
                    begin
                        if (out_reg.final_res)
                        begin
                            cnt_reg <= '0;
                            ovf_reg <= 1'b0;
                        end
                        else
                            emit_reg <= emit_reg + 1'b1;
                    end
                default:
                    ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == dnms_pkg::ST_SCAN_CMP && better)
            cand_reg <= row_rd_reg;
        iw_reg <= (dx > 14'sd0) ? dx[11:0] : 12'd0;
        ih_reg <= (dy > 14'sd0) ? dy[11:0] : 12'd0;
        ssx_reg <= surv_rd_reg.span_x;
        ssy_reg <= surv_rd_reg.span_y;
        inter_reg <= iw_reg * ih_reg;
        area_s_reg <= ssx_reg * ssy_reg;
        area_c_reg <= cand_reg.span_x * cand_reg.span_y;
        union_reg <= 25'(area_s_reg) + 25'(area_c_reg) - 25'(inter_reg);
        if (state_reg == dnms_pkg::ST_EMIT_LD)
        begin
            out_reg.left <= surv_rd_reg.left;
            out_reg.top <= surv_rd_reg.top;
            out_reg.span_x <= surv_rd_reg.span_x;
            out_reg.span_y <= surv_rd_reg.span_y;
            out_reg.score <= surv_rd_reg.conf;
            out_reg.label <= surv_rd_reg.label;
            out_reg.final_res <= (CNT_W'(emit_reg) + 1'b1) == surv_cnt_reg;
            out_reg.no_boxes <= 1'b0;
            out_reg.dropped <= ovf_reg;
        end
        else if (state_reg == dnms_pkg::ST_MARK)
            out_reg <= '{final_res: 1'b1, no_boxes: 1'b1, dropped: ovf_reg, default: '0};
    end

    assign out_data = out_reg;

endmodule

// File: design/detection_decode_and_nms_core.sv
// Rows enter at one per cycle while a frame is collected; each passes a four-stage decode
// and, if kept and the store has room, is appended to the box store. The row marked
// frame_end holds row_stall high until the last result of the frame is taken. Ordering
// and suppression then walk the row and survivor stores: for each of the n kept boxes the
// rows are scanned for the highest untaken confidence and the pick is tested against each
// survivor in turn; each result is then held on the output while it stalls.
// Depends on dnms_pkg, dnms_decode and dnms_engine.
module detection_decode_and_nms_core
#(
    parameter int MAX_KEPT = dnms_pkg::MAX_KEPT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        row_valid,
    output logic                        row_stall,
    input  dnms_pkg::row_t              row,
    output logic                        det_valid,
    input  logic                        det_stall,
    output dnms_pkg::det_t              det,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dnms_pkg::ADDR_W-1:0] paddr,
    input  logic [dnms_pkg::DATA_W-1:0] pwdata,
    output logic [dnms_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    logic [15:0] score_thr_reg, overlap_thr_reg;
    logic [12:0] img_w_reg, img_h_reg;
    logic [19:0] scale_x_reg, scale_y_reg;
    logic        busy_reg, row_accept, cfg_write, done;
    dnms_pkg::reg_idx_t reg_idx;
    dnms_pkg::dec_out_t dec;

    assign pready = 1'b1;
    assign reg_idx = dnms_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;
    assign row_accept = row_valid && !busy_reg;
    assign row_stall = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg <= dnms_pkg::SCORE_THR_RST;
            overlap_thr_reg <= dnms_pkg::OVERLAP_THR_RST;
            img_w_reg <= dnms_pkg::IMG_DIM_RST;
            img_h_reg <= dnms_pkg::IMG_DIM_RST;
            scale_x_reg <= dnms_pkg::SCALE_RST;
            scale_y_reg <= dnms_pkg::SCALE_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                dnms_pkg::REG_SCORE_THR:   score_thr_reg <= pwdata[15:0];
                dnms_pkg::REG_OVERLAP_THR: overlap_thr_reg <= pwdata[15:0];
                dnms_pkg::REG_IMG_W:       img_w_reg <= pwdata[12:0];
                dnms_pkg::REG_IMG_H:       img_h_reg <= pwdata[12:0];
                dnms_pkg::REG_SCALE_X:     scale_x_reg <= pwdata[19:0];
                dnms_pkg::REG_SCALE_Y:     scale_y_reg <= pwdata[19:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dnms_pkg::REG_SCORE_THR:   prdata = 32'(score_thr_reg);
            dnms_pkg::REG_OVERLAP_THR: prdata = 32'(overlap_thr_reg);
            dnms_pkg::REG_IMG_W:       prdata = 32'(img_w_reg);
            dnms_pkg::REG_IMG_H:       prdata = 32'(img_h_reg);
            dnms_pkg::REG_SCALE_X:     prdata = 32'(scale_x_reg);
            dnms_pkg::REG_SCALE_Y:     prdata = 32'(scale_y_reg);
            default:                   prdata = '0;
        endcase
    end

    // input closes on the last row of a frame, reopens once its results are out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (row_accept && row.frame_end)
            busy_reg <= 1'b1;
        else if (done)
            busy_reg <= 1'b0;
    end

    dnms_decode u_decode
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (row_accept),
        .row             (row),
        .score_threshold (score_thr_reg),
        .image_width     (img_w_reg),
        .image_height    (img_h_reg),
        .scale_x         (scale_x_reg),
        .scale_y         (scale_y_reg),
        .dec             (dec)
    );

    dnms_engine #(.MAX_KEPT(MAX_KEPT)) u_engine
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .dec               (dec),
        .overlap_threshold (overlap_thr_reg),
        .out_valid         (det_valid),
        .out_stall         (det_stall),
        .out_data          (det),
        .done              (done)
    );

endmodule

// File: design/dnms_checker.sv
// Port-level checks for the detection decode and suppression core, bound to the top level.
// Depends on dnms_pkg.
module dnms_port_checks
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        row_valid,
    input logic                        row_stall,
    input dnms_pkg::row_t              row,
    input logic                        det_valid,
    input logic                        det_stall,
    input dnms_pkg::det_t              det
);

    // a stalled result holds
    a_det_hold: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid && det_stall |=> det_valid && $stable(det))
        else $error("result changed while stalled");

    // the last row of a frame closes the input
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_stall && row.frame_end |=> row_stall)
        else $error("input open after last row");

    // results only appear while the input is closed
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid |-> row_stall)
        else $error("result while collecting");

    // the empty marker ends the frame and carries no box
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid && det.no_boxes |-> det.final_res && det.span_x == 12'd0
            && det.span_y == 12'd0 && det.score == 16'd0)
        else $error("bad empty marker");

    // a delivered box is never empty
    a_box: assert property (@(posedge clk) disable iff (!rst_n)
        det_valid && !det.no_boxes |-> det.span_x != 12'd0 && det.span_y != 12'd0)
        else $error("empty box emitted");

endmodule

bind detection_decode_and_nms_core dnms_port_checks u_dnms_port_checks (.*);
